>>> hw/rtl/c608_pkg.sv
// ---------------------------------------------------------------------------
// c608_pkg
// shared types and constants for the caption line extractor
// ---------------------------------------------------------------------------
package c608_pkg;

  localparam int unsigned LINE_CAP_DEF = 64;
  localparam int unsigned CAP_MAX      = 64;
  localparam logic [7:0]  BYTE_NULL    = 8'h80;
  localparam logic [6:0]  CHAR_SPACE   = 7'h20;
  localparam logic [4:0]  NO_ROW       = 5'h1f;

  // operation codes handed from the front end to the line engine
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_TEXT  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  ch_a;
    logic        a_ok;
    logic [6:0]  ch_b;
    logic        b_ok;
    logic        set_start;
    logic [31:0] now_ms;
  } c608_cmd_t;

  function automatic logic [6:0] strip_parity(input logic [7:0] raw);
    strip_parity = (^raw) ? raw[6:0] : 7'd0;
  endfunction

  function automatic logic [4:0] row_of(input logic [6:0] a, input logic [6:0] b);
    logic up;
    logic lo;
    up = (b >= 7'h40) && (b <= 7'h5f);
    lo = (b >= 7'h60);
    row_of = NO_ROW;
    if (up || lo) begin
      unique case (a)
        7'h11:   row_of = up ? 5'd0 : 5'd1;
        7'h12:   row_of = up ? 5'd2 : 5'd3;
        7'h10:   row_of = up ? 5'd10 : NO_ROW;
        7'h13:   row_of = up ? 5'd11 : 5'd12;
        7'h14:   row_of = up ? 5'd13 : 5'd14;
        default: row_of = NO_ROW;
      endcase
    end
  endfunction

endpackage

>>> hw/rtl/caption_608_line_extractor.sv
// ---------------------------------------------------------------------------
// caption_608_line_extractor
// caption byte pair decoder that emits trimmed channel-one text lines
// ---------------------------------------------------------------------------
// usage:
//   in_ channel: one request per caption byte pair (pair_ok, two raw bytes
//   with parity, sample time). out_ channel: one request per character of a
//   flushed line, all stamped with the line start time, last_of_line on the
//   final character.
//   a decoder accepts a pair per cycle while the two-entry queue has room;
//   the line engine takes one command at a time. a text pair with a second
//   character passes through an extra state in the engine. a flush scans
//   the buffer through its registered read port, one trim pass for leading
//   and one for trailing spaces, then emits the characters one at a time
//   as the receiver takes them.
//   reset clears channel, command, row, length and start time; the buffer
//   contents are not cleared.
//   a stalled receiver holds the result; the engine waits, the queue fills,
//   then in_ready drops.
// ---------------------------------------------------------------------------
module caption_608_line_extractor #(
  parameter int unsigned LINE_CAPACITY = c608_pkg::LINE_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_pair_ok,
  input  logic [7:0]  in_first_byte,
  input  logic [7:0]  in_second_byte,
  input  logic [31:0] in_sample_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_char_code,
  output logic [31:0] out_line_time_ms,
  output logic        out_last_of_line
);

  // decoded command stream from front end into queue
  c608_pkg::c608_cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;

  c608_front u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .pair_ok(in_pair_ok), .first_byte(in_first_byte),
    .second_byte(in_second_byte), .sample_ms(in_sample_ms),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  // decouples decode from line emission
  c608_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  c608_back #(.LINE_CAPACITY(LINE_CAPACITY)) u_back (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid, .out_ready, .out_char_code, .out_line_time_ms,
    .out_last_of_line
  );

endmodule

>>> hw/rtl/c608_front.sv
// ---------------------------------------------------------------------------
// c608_front
// decodes byte pairs, tracks channel / command / row state, issues commands
// ---------------------------------------------------------------------------
module c608_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               pair_ok,
  input  logic [7:0]         first_byte,
  input  logic [7:0]         second_byte,
  input  logic [31:0]        sample_ms,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output c608_pkg::c608_cmd_t cmd
);

  logic        chan1_r, chan1_nxt;
  logic [13:0] prev_cmd_r, prev_cmd_nxt;
  logic [4:0]  prev_row_r, prev_row_nxt;
  logic [6:0]  a, b;
  logic [13:0] cur;
  logic [4:0]  row;
  logic        live, acc;

  assign in_ready  = cmd_ready;
  assign acc       = in_valid && in_ready;
  assign a         = c608_pkg::strip_parity(first_byte);
  assign b         = c608_pkg::strip_parity(second_byte);
  assign cur       = {a, b};
  assign row       = c608_pkg::row_of(a, b);
  assign live      = pair_ok && !(first_byte == c608_pkg::BYTE_NULL &&
                                  second_byte == c608_pkg::BYTE_NULL);
  assign cmd_valid = in_valid;

  always_comb begin
    chan1_nxt     = chan1_r;
    prev_cmd_nxt  = prev_cmd_r;
    prev_row_nxt  = prev_row_r;
    cmd           = '0;
    cmd.op        = c608_pkg::OP_NONE;
    cmd.ch_a      = a;
    cmd.ch_b      = b;
    cmd.set_start = live;
    cmd.now_ms    = sample_ms;
    if (live) begin
      priority if (a >= 7'h20 && chan1_r) begin
        cmd.op   = c608_pkg::OP_TEXT;
        cmd.a_ok = 1'b1;
        cmd.b_ok = (b >= 7'h20);
      end else if (a >= 7'h10 && a <= 7'h14) begin
        chan1_nxt = 1'b1;
        if (cur != prev_cmd_r) begin
          prev_cmd_nxt = cur;
          priority if ((a == 7'h11 && b >= 7'h20 && b <= 7'h2f) ||
                       (a == 7'h14 && b == 7'h28)) begin
            cmd.op   = c608_pkg::OP_TEXT;
            cmd.ch_a = c608_pkg::CHAR_SPACE;
            cmd.a_ok = 1'b1;
          end else if (a == 7'h14 && (b == 7'h20 || b == 7'h2c || b == 7'h2d ||
                                      b == 7'h2e || b == 7'h2f)) begin
            cmd.op = c608_pkg::OP_FLUSH;
            if (b == 7'h2e) prev_row_nxt = c608_pkg::NO_ROW;
          end else if (row != c608_pkg::NO_ROW && row != prev_row_r) begin
            cmd.op       = c608_pkg::OP_FLUSH;
            prev_row_nxt = row;
          end else begin
            cmd.op = c608_pkg::OP_NONE;
          end
        end
      end else if (a >= 7'h18 && a <= 7'h1f) begin
        chan1_nxt = 1'b0;
      end else begin
        cmd.op = c608_pkg::OP_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan1_r    <= 1'b1;
      prev_cmd_r <= '0;
      prev_row_r <= c608_pkg::NO_ROW;
    end else if (acc) begin
      chan1_r    <= chan1_nxt;
      prev_cmd_r <= prev_cmd_nxt;
      prev_row_r <= prev_row_nxt;
    end
  end

endmodule

>>> hw/rtl/c608_queue.sv
// ---------------------------------------------------------------------------
// c608_queue
// two-entry command queue between decoder and line engine
// ---------------------------------------------------------------------------
module c608_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  c608_pkg::c608_cmd_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output c608_pkg::c608_cmd_t rd_data
);

  c608_pkg::c608_cmd_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

>>> hw/rtl/c608_back.sv
// ---------------------------------------------------------------------------
// c608_back
// line buffer: appends characters, trims and streams a line on flush
// ---------------------------------------------------------------------------
module c608_back #(
  parameter int unsigned LINE_CAPACITY = c608_pkg::LINE_CAP_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  c608_pkg::c608_cmd_t cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [6:0]          out_char_code,
  output logic [31:0]         out_line_time_ms,
  output logic                out_last_of_line
);

  localparam int unsigned AW = $clog2(LINE_CAPACITY);
  localparam logic [6:0]  CAP = 7'(LINE_CAPACITY);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LEAD = 3'd1;
  localparam logic [2:0] ST_TAIL = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_B    = 3'd4;

  logic [6:0]  buf_r [LINE_CAPACITY];
  logic [2:0]  st_r;
  logic [6:0]  len_r, first_r, last_r, idx_r;
  logic [31:0] start_r, now_r;
  logic [6:0]  ch_b_r;
  logic [6:0]  rd_data_r;
  logic        rd_ok_r;
  logic [6:0]  wr_len;
  logic        take, out_fire;

  assign cmd_ready = (st_r == ST_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign out_fire  = out_valid && out_ready;

  // buffer write: first char at len, second char in the cycle after, from ST_B
  always_ff @(posedge clk) begin
    if (take && cmd.op == c608_pkg::OP_TEXT && cmd.a_ok && len_r < CAP)
      buf_r[len_r[AW-1:0]] <= cmd.ch_a;
    else if (st_r == ST_B && len_r < CAP)
      buf_r[len_r[AW-1:0]] <= ch_b_r;
  end

  // registered read of the scan index
  always_ff @(posedge clk) begin
    rd_data_r <= buf_r[idx_r[AW-1:0]];
  end

  assign wr_len = len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      len_r     <= '0;
      start_r   <= '0;
      out_valid <= 1'b0;
      rd_ok_r   <= 1'b0;
      idx_r     <= '0;
    end else begin
      rd_ok_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (take) begin
            if (cmd.set_start && start_r == '0) start_r <= cmd.now_ms;
            now_r <= cmd.now_ms;
            unique case (cmd.op)
              c608_pkg::OP_TEXT: begin
                if (wr_len < CAP) len_r <= wr_len + 7'd1;
                ch_b_r <= cmd.ch_b;
                if (cmd.b_ok) st_r <= ST_B;
              end
              c608_pkg::OP_FLUSH: begin
                idx_r   <= '0;
                first_r <= '0;
                if (len_r == '0) st_r <= ST_IDLE;
                else st_r <= ST_LEAD;
              end
              default: st_r <= ST_IDLE;
            endcase
          end
        end
        ST_B: begin
          if (len_r < CAP) len_r <= len_r + 7'd1;
          st_r <= ST_IDLE;
        end
        ST_LEAD: begin
          // skip leading spaces, waiting on the registered read for each entry
          if (rd_ok_r) begin
            if (rd_data_r == c608_pkg::CHAR_SPACE) begin
              if (idx_r + 7'd1 >= len_r) begin
                len_r <= '0;
                st_r  <= ST_IDLE;
              end else begin
                idx_r <= idx_r + 7'd1;
              end
            end else begin
              first_r <= idx_r;
              idx_r   <= len_r - 7'd1;
              last_r  <= len_r;
              st_r    <= ST_TAIL;
            end
          end else begin
            rd_ok_r <= 1'b1;
          end
        end
        ST_TAIL: begin
          if (rd_ok_r) begin
            if (rd_data_r == c608_pkg::CHAR_SPACE) begin
              last_r <= idx_r;
              idx_r  <= idx_r - 7'd1;
            end else begin
              last_r <= idx_r + 7'd1;
              idx_r  <= first_r;
              st_r   <= ST_EMIT;
            end
          end else begin
            rd_ok_r <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_fire) begin
            out_valid <= 1'b0;
            if (out_last_of_line) begin
              len_r   <= '0;
              start_r <= now_r;
              st_r    <= ST_IDLE;
            end else begin
              idx_r <= idx_r + 7'd1;
            end
          end else if (!out_valid && rd_ok_r) begin
            out_valid        <= 1'b1;
            out_char_code    <= rd_data_r;
            out_line_time_ms <= start_r;
            out_last_of_line <= (idx_r + 7'd1 == last_r);
          end else if (!out_valid) begin
            rd_ok_r <= 1'b1;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n) len_r <= CAP)
    else $error("line length beyond capacity");
  a_out_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> st_r == ST_EMIT) else $error("result outside emit");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !cmd_ready) else $error("command taken while busy");

endmodule

>>> bench/caption_608_line_extractor_test.sv
// ---------------------------------------------------------------------------
// caption_608_line_extractor_test
// checks the caption line extractor against an in-bench line predictor,
// with directed control codes first and random caption traffic after
// ---------------------------------------------------------------------------
module caption_608_line_extractor_test;

  // control pair codes, parity stripped
  localparam logic [6:0] CC_ROW10    = 7'h10;
  localparam logic [6:0] CC_MIDROW   = 7'h11;
  localparam logic [6:0] CC_ROW2     = 7'h12;
  localparam logic [6:0] CC_ROW11    = 7'h13;
  localparam logic [6:0] CC_MISC     = 7'h14;
  localparam logic [6:0] CC_CH2_LO   = 7'h18;
  localparam logic [6:0] CC_RCL      = 7'h20;
  localparam logic [6:0] CC_FON      = 7'h28;
  localparam logic [6:0] CC_EDM      = 7'h2c;
  localparam logic [6:0] CC_CR       = 7'h2d;
  localparam logic [6:0] CC_ENM      = 7'h2e;
  localparam logic [6:0] CC_EOC      = 7'h2f;
  localparam logic [6:0] CC_PAC_UP   = 7'h40;
  localparam logic [6:0] CC_PAC_LO   = 7'h60;
  localparam int         LINE_SLOTS  = 64;
  localparam int         TAIL_CYCLES = 400;
  localparam int         CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [6:0]  ch;
    logic [31:0] stamp;
    logic        last;
  } caption_char_t;

  // line predictor and the queue of characters it expects
  class caption_line_board;
    caption_char_t expected_chars[$];
    logic [6:0]    line_buf[LINE_SLOTS];
    int            line_len;
    bit            chan_one;
    logic [15:0]   last_cmd;
    logic [4:0]    last_row;
    logic [31:0]   start_ms;
    int            errors;
    int            flushes;
    int            seen_chars;

    function new();
      line_len = 0;
      chan_one = 1'b1;
      last_cmd = '0;
      last_row = c608_pkg::NO_ROW;
      start_ms = '0;
      errors = 0;
      flushes = 0;
      seen_chars = 0;
    endfunction

    task report(input string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    function logic [6:0] clean(input logic [7:0] raw);
      return ($countones(raw) % 2 == 1) ? raw[6:0] : 7'd0;
    endfunction

    function void append(input logic [6:0] c);
      if (line_len < LINE_SLOTS) begin
        line_buf[line_len] = c;
        line_len++;
      end
    endfunction

    function logic [4:0] pac_row(input logic [6:0] a, input logic [6:0] b);
      bit up;
      bit lo;
      up = (b >= 7'h40 && b <= 7'h5f);
      lo = (b >= 7'h60);
      if (!up && !lo) return c608_pkg::NO_ROW;
      case (a)
        CC_MIDROW: return up ? 5'd0 : 5'd1;
        CC_ROW2:   return up ? 5'd2 : 5'd3;
        CC_ROW10:  return up ? 5'd10 : c608_pkg::NO_ROW;
        CC_ROW11:  return up ? 5'd11 : 5'd12;
        CC_MISC:   return up ? 5'd13 : 5'd14;
        default:   return c608_pkg::NO_ROW;
      endcase
    endfunction

    function void flush(input logic [31:0] now);
      int lo_i;
      int hi_i;
      caption_char_t c;
      lo_i = 0;
      while (lo_i < line_len && line_buf[lo_i] == c608_pkg::CHAR_SPACE) lo_i++;
      hi_i = line_len;
      while (hi_i > lo_i && line_buf[hi_i-1] == c608_pkg::CHAR_SPACE) hi_i--;
      line_len = 0;
      if (hi_i == lo_i) return;
      flushes++;
      for (int i = lo_i; i < hi_i; i++) begin
        c.ch = line_buf[i];
        c.stamp = start_ms;
        c.last = (i + 1 == hi_i);
        expected_chars.push_back(c);
      end
      start_ms = now;
    endfunction

    // one accepted request
    function void note_pair(input logic ok, input logic [7:0] fb, input logic [7:0] sb,
                            input logic [31:0] now);
      logic [6:0]  a;
      logic [6:0]  b;
      logic [15:0] cmd;
      logic [4:0]  row;
      if (!ok) return;
      if (fb == c608_pkg::BYTE_NULL && sb == c608_pkg::BYTE_NULL) return;
      if (start_ms == 0) start_ms = now;
      a = clean(fb);
      b = clean(sb);
      if (a >= 7'h20 && chan_one) begin
        append(a);
        if (b >= 7'h20) append(b);
        return;
      end
      if (a >= CC_ROW10 && a <= CC_MISC) begin
        chan_one = 1'b1;
        cmd = {1'b0, a, 1'b0, b};
        if (cmd == last_cmd) return;
        last_cmd = cmd;
        if ((a == CC_MIDROW && b >= 7'h20 && b <= 7'h2f) || (a == CC_MISC && b == CC_FON)) begin
          append(c608_pkg::CHAR_SPACE);
          return;
        end
        if (a == CC_MISC && (b == CC_RCL || b == CC_EDM || b == CC_CR || b == CC_ENM ||
                             b == CC_EOC)) begin
          if (b == CC_ENM) last_row = c608_pkg::NO_ROW;
          flush(now);
          return;
        end
        row = pac_row(a, b);
        if (row != c608_pkg::NO_ROW && row != last_row) begin
          flush(now);
          last_row = row;
        end
        return;
      end
      if (a >= CC_CH2_LO) chan_one = 1'b0;
    endfunction

    task check(input logic [6:0] ch, input logic [31:0] stamp, input logic last);
      caption_char_t e;
      seen_chars++;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char %h time %0d", ch, stamp));
        return;
      end
      e = expected_chars.pop_front();
      if (ch !== e.ch || stamp !== e.stamp || last !== e.last)
        report($sformatf("got char %h time %0d last %b, want %h %0d %b",
                         ch, stamp, last, e.ch, e.stamp, e.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_pair_ok = 1'b0;
  logic [7:0]  in_first_byte = '0;
  logic [7:0]  in_second_byte = '0;
  logic [31:0] in_sample_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  out_char_code;
  logic [31:0] out_line_time_ms;
  logic        out_last_of_line;

  caption_line_board board = new();
  int  requests_taken = 0;
  int  cycles = 0;
  bit  steady = 1'b0;   // no idling on either side while set
  logic [31:0] clock_ms = 32'hffff_ff00;

  always #1 clk = ~clk;

  caption_608_line_extractor dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pair_ok(in_pair_ok),
    .in_first_byte(in_first_byte), .in_second_byte(in_second_byte),
    .in_sample_ms(in_sample_ms),
    .out_valid(out_valid), .out_ready(out_ready), .out_char_code(out_char_code),
    .out_line_time_ms(out_line_time_ms), .out_last_of_line(out_last_of_line)
  );

  // handshakes sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
    if (rst_n) begin
      if (in_valid && in_ready) begin
        board.note_pair(in_pair_ok, in_first_byte, in_second_byte, in_sample_ms);
        requests_taken++;
      end
      if (out_valid && out_ready)
        board.check(out_char_code, out_line_time_ms, out_last_of_line);
    end
  end

  // receiver stalls about one cycle in six
  always @(negedge clk) begin
    out_ready = steady ? 1'b1 : ($urandom_range(99) >= 16);
  end

  // add the odd parity bit
  function automatic logic [7:0] odd(input logic [6:0] c);
    return {~(^c), c};
  endfunction

  // one request, held until taken
  task send(input logic ok, input logic [7:0] fb, input logic [7:0] sb, input logic [31:0] ms);
    int taken;
    if (!steady && $urandom_range(99) < 16) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_pair_ok = ok;
    in_first_byte = fb;
    in_second_byte = sb;
    in_sample_ms = ms;
    taken = requests_taken;
    do @(negedge clk); while (requests_taken == taken);
    in_valid = 1'b0;
  endtask

  function automatic logic [31:0] next_ms();
    clock_ms += $urandom_range(1, 40);
    return clock_ms;
  endfunction

  task send_ctrl(input logic [6:0] a, input logic [6:0] b);
    send(1'b1, odd(a), odd(b), next_ms());
  endtask

  task send_text(input logic [6:0] a, input logic [6:0] b);
    send(1'b1, odd(a), odd(b), next_ms());
  endtask

  function automatic logic [6:0] any_text();
    return ($urandom_range(3) == 0) ? c608_pkg::CHAR_SPACE : 7'($urandom_range(32, 127));
  endfunction

  // mostly well formed caption traffic, some noise
  task random_pair();
    int pick;
    logic [6:0] a;
    logic [6:0] b;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_text(any_text(), ($urandom_range(4) == 0) ? 7'h00 : any_text());
    end else if (pick < 75) begin
      a = 7'($urandom_range(CC_ROW10, CC_MISC));
      case ($urandom_range(4))
        0: begin a = CC_MISC; b = CC_EOC; end
        1: begin
          a = CC_MISC;
          case ($urandom_range(4))
            0: b = CC_RCL;
            1: b = CC_EDM;
            2: b = CC_CR;
            3: b = CC_ENM;
            default: b = CC_FON;
          endcase
        end
        2: b = 7'($urandom_range(CC_PAC_UP, 7'h7f));
        3: begin a = CC_MIDROW; b = 7'($urandom_range(7'h20, 7'h2f)); end
        default: b = 7'($urandom_range(0, 127));
      endcase
      send_ctrl(a, b);
    end else if (pick < 85) begin
      send(1'b1, 8'($urandom), 8'($urandom),
           ($urandom_range(9) == 0) ? $urandom : next_ms());
    end else if (pick < 90) begin
      send(1'b1, c608_pkg::BYTE_NULL, c608_pkg::BYTE_NULL, next_ms());
    end else if (pick < 95) begin
      send(1'b0, 8'($urandom), 8'($urandom), $urandom);
    end else begin
      send_ctrl(7'($urandom_range(CC_CH2_LO, 7'h1f)), 7'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    int real_items;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: ignored items, text, parity errors, each control code
    send(1'b0, 8'hff, 8'h00, 32'hffff_ffff);
    send(1'b1, c608_pkg::BYTE_NULL, c608_pkg::BYTE_NULL, 32'd0);
    send(1'b1, odd(7'h48), odd(7'h49), 32'd0);            // time zero keeps start open
    send(1'b1, {odd(7'h41) ^ 8'h80}, 8'hff, 32'd5);       // both bytes fail parity
    send_ctrl(CC_MIDROW, CC_RCL);                          // mid-row space
    send_ctrl(CC_MIDROW, CC_RCL);                          // repeat, suppressed
    send_ctrl(CC_MISC, CC_FON);                            // flash adds space
    send_text(c608_pkg::CHAR_SPACE, 7'h7f);
    send_ctrl(CC_MISC, CC_EOC);                            // flush
    send_ctrl(CC_MIDROW, CC_PAC_UP);                       // new row, empty line
    send_text(7'h20, 7'h41);
    send_ctrl(CC_ROW2, CC_PAC_LO);                         // row change flushes
    send_ctrl(CC_ROW10, CC_PAC_LO);                        // no such row
    send_ctrl(CC_ROW11, CC_PAC_UP);
    send_ctrl(7'h1c, CC_RCL);                              // channel two
    send_text(7'h5a, 7'h5a);                               // dropped on channel two
    send_ctrl(CC_MISC, CC_ENM);                            // back to channel one
    send_text(7'h7e, c608_pkg::CHAR_SPACE);
    send_ctrl(CC_MISC, CC_RCL);
    send_text(7'h31, 7'h32);
    send_ctrl(CC_MISC, CC_EDM);
    send_text(7'h33, 7'h00);
    send_ctrl(CC_MISC, CC_CR);
    send(1'b1, odd(7'h7f), odd(7'h20), 32'hffff_ffff);
    send_ctrl(CC_MISC, CC_EOC);

    // random traffic, long full-rate stretch in the middle
    real_items = 0;
    while (real_items < 200) begin
      steady = (real_items >= 90 && real_items < 130);
      if ($urandom_range(99) < 3) begin
        // overfill the line, then close it
        repeat (36) send_text(any_text(), any_text());
        send_ctrl(CC_MISC, CC_EOC);
        real_items += 37;
      end else begin
        random_pair();
        real_items++;
      end
    end
    steady = 1'b0;

    // drain, then give a flush still in flight time to show up
    while (board.expected_chars.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (board.expected_chars.size() != 0)
      board.report($sformatf("%0d chars never arrived", board.expected_chars.size()));

    $display("covered %0d requests, %0d lines flushed, %0d chars checked",
             requests_taken, board.flushes, board.seen_chars);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/c608_pkg.sv
hw/rtl/c608_front.sv
hw/rtl/c608_queue.sv
hw/rtl/c608_back.sv
hw/rtl/caption_608_line_extractor.sv
bench/caption_608_line_extractor_test.sv
